// File: rtl/hbrc_pkg.sv
// Shared constants and codes of the H-bridge relay actuator controller.
// Depends on nothing. It is imported by hbridge_relay_actuator_controller_core.
`default_nettype none

package hbrc_pkg;

  // Number of relay blocks. Each block holds two actuators.
  localparam int BLOCK_COUNT = 8;
  localparam int NUM_ACT     = 2 * BLOCK_COUNT;
  localparam int ACT_W       = $clog2(NUM_ACT);

  localparam int PHASE_W = 20;
  localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};

  // Configuration register widths and reset values.
  localparam int DEADTIME_W = 10;
  localparam int TIMEOUT_W  = 20;
  localparam logic [DEADTIME_W-1:0] DEADTIME_RST   = 10'd50;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST    = 20'd30000;
  localparam logic                  ACTIVE_LOW_RST = 1'b1;

  // Configuration register indexes (byte address / 4).
  localparam logic [1:0] REG_DEADTIME   = 2'd0;
  localparam logic [1:0] REG_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_ACTIVE_LOW = 2'd2;

  // Input transaction kinds.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_BLOCK = 2'd1;
  localparam logic [1:0] FUNC_ALL   = 2'd2;
  localparam logic [1:0] FUNC_PING  = 2'd3;

  // Actions.
  localparam logic [1:0] ACT_UP    = 2'd0;
  localparam logic [1:0] ACT_DOWN  = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_OTHER = 2'd3;

  // Commanded directions.
  localparam logic [1:0] DIR_OFF  = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_PONG     = 3'd0;
  localparam logic [2:0] KIND_BLK_ACK  = 3'd1;
  localparam logic [2:0] KIND_ALL_ACK  = 3'd2;
  localparam logic [2:0] KIND_ALL_STOP = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN  = 3'd4;
  localparam logic [2:0] KIND_TIMEOUT  = 3'd5;

  // One result before packing.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  report_block;
    logic        actuator_sel;
    logic [1:0]  action_echo;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/hbridge_relay_actuator_controller_core.sv
// H-bridge relay actuator controller: command sequencer, per-actuator timers
// and relay outputs. Depends on hbrc_pkg.
`default_nettype none

// Channel   Direction  Fields (low bit first)
// in_*      input      tuser: func[1:0]; tdata: block_id[7:0], action[9:8]
// out_*     output     tuser: kind[2:0]; tdata: report_block[7:0],
//                      actuator_sel[8], action_echo[10:9], relay_drive[42:11];
//                      tlast: last
// cfg_*     APB        deadtime 0x0, timeout 0x4, relay_active_low 0x8
//
// A transaction is taken only in the idle state. A block command, an all-blocks
// command or a tick then scans the NUM_ACT actuators one per cycle through a
// single timer incrementer and comparator; a command then loads its result into
// the output register and returns to idle. A tick with timeouts then walks the
// timeout mask, one actuator per cycle unless a stalled output holds it, and
// reports each flagged actuator. A ping or an unknown block skips the scan and
// goes straight to loading its result. A stalled output holds the sequencer;
// the output register lets the last result wait while the next transaction is
// taken.
// Reset (rst_n, synchronous) stops every actuator and loads the register
// defaults; there is no clearing pass.
module hbridge_relay_actuator_controller_core
  import hbrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // block_id[7:0], action[9:8], zero pad
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // report_block[7:0], actuator_sel[8],
                                       // action_echo[10:9], relay_drive[42:11], pad
  output logic [2:0]       out_tuser,  // kind[2:0]
  output logic             out_tlast,
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  localparam logic [ACT_W-1:0] IDX_LAST = ACT_W'(NUM_ACT - 1);

  // Configuration registers.
  logic [DEADTIME_W-1:0] deadtime_r;
  logic [TIMEOUT_W-1:0]  timeout_r;
  logic                  active_low_r;

  // Per-actuator state.
  logic [1:0]         dir_r [NUM_ACT];
  logic [NUM_ACT-1:0] dt_r;
  logic [PHASE_W-1:0] ph_r  [NUM_ACT];

  // Sequencer.
  logic [1:0]         state_r, state_nxt;
  logic [ACT_W-1:0]   idx_r, idx_nxt;
  logic [1:0]         func_r, func_nxt;
  logic [7:0]         id_r, id_nxt;
  logic [1:0]         action_r, action_nxt;
  logic [NUM_ACT-1:0] to_mask_r, to_mask_nxt;

  // Output register.
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [2:0]  out_tuser_r;
  logic [47:0] out_tdata_r;
  logic        out_tlast_r;

  logic       in_fire;
  logic       cfg_wr;
  logic       slot_free;
  logic       load;
  result_t    res;
  logic       id_unknown;
  logic [31:0] on_bits;
  logic [31:0] relay_lv;

  // Shared timer unit and write-back for the actuator under the scan index.
  logic [1:0]         cur_dir;
  logic               cur_dt;
  logic [PHASE_W-1:0] cur_ph;
  logic [PHASE_W-1:0] ph_inc;
  logic [PHASE_W:0]   lim;
  logic               reach;
  logic               blk_sel;
  logic               wr_en;
  logic [1:0]         wr_dir;
  logic               wr_dt;
  logic [PHASE_W-1:0] wr_ph;
  logic               wr_to;
  logic [1:0]         mv_dir;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign slot_free  = ~out_tvalid_r | out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  assign id_unknown = (id_r == 8'd0) || (id_r > 8'(BLOCK_COUNT));

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_DEADTIME:   cfg_prdata = {22'd0, deadtime_r};
      REG_TIMEOUT:    cfg_prdata = {12'd0, timeout_r};
      REG_ACTIVE_LOW: cfg_prdata = {31'd0, active_low_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadtime_r   <= DEADTIME_RST;
      timeout_r    <= TIMEOUT_RST;
      active_low_r <= ACTIVE_LOW_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_DEADTIME:   deadtime_r   <= cfg_pwdata[DEADTIME_W-1:0];
        REG_TIMEOUT:    timeout_r    <= cfg_pwdata[TIMEOUT_W-1:0];
        REG_ACTIVE_LOW: active_low_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Relay levels follow the stored state; actuators in deadtime stay off.
  always_comb begin
    on_bits = 32'd0;
    for (int a = 0; a < NUM_ACT; a++) begin
      on_bits[2*a]   = ~dt_r[a] & (dir_r[a] == DIR_UP);
      on_bits[2*a+1] = ~dt_r[a] & (dir_r[a] == DIR_DOWN);
    end
    relay_lv = active_low_r ? ~on_bits : on_bits;
  end

  // One actuator per scan cycle. The incrementer saturates; the comparator
  // checks against the deadtime while waiting and timeout + 1 while driving.
  always_comb begin
    cur_dir = dir_r[idx_r];
    cur_dt  = dt_r[idx_r];
    cur_ph  = ph_r[idx_r];
    ph_inc  = (cur_ph == PHASE_MAX) ? cur_ph : cur_ph + PHASE_W'(1);
    lim     = cur_dt ? (PHASE_W+1)'(deadtime_r)
                     : (PHASE_W+1)'(timeout_r) + (PHASE_W+1)'(1);
    reach   = {1'b0, ph_inc} >= lim;
    blk_sel = (func_r == FUNC_ALL) ||
              (8'(idx_r >> 1) == (id_r - 8'd1));
    mv_dir  = (action_r == ACT_UP) ? DIR_UP : DIR_DOWN;

    wr_en  = 1'b0;
    wr_dir = cur_dir;
    wr_dt  = cur_dt;
    wr_ph  = cur_ph;
    wr_to  = 1'b0;

    if (state_r == ST_SCAN) begin
      if (func_r == FUNC_TICK) begin
        if (cur_dir != DIR_OFF) begin
          wr_en = 1'b1;
          if (cur_dt) begin
            if (reach) begin
              wr_dt = 1'b0;
              wr_ph = '0;
            end else begin
              wr_ph = ph_inc;
            end
          end else if (reach) begin
            // Drive time exceeded: stop and flag for a timeout report.
            wr_dir = DIR_OFF;
            wr_dt  = 1'b0;
            wr_ph  = '0;
            wr_to  = 1'b1;
          end else begin
            wr_ph = ph_inc;
          end
        end
      end else if (blk_sel) begin
        if (action_r == ACT_STOP) begin
          wr_en  = 1'b1;
          wr_dir = DIR_OFF;
          wr_dt  = 1'b0;
          wr_ph  = '0;
        end else if (action_r != ACT_OTHER && cur_dir != mv_dir) begin
          // A move toward the held direction is ignored.
          wr_en  = 1'b1;
          wr_dir = mv_dir;
          wr_dt  = (deadtime_r != '0);
          wr_ph  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= '0;
      for (int a = 0; a < NUM_ACT; a++) begin
        dir_r[a] <= DIR_OFF;
        ph_r[a]  <= '0;
      end
    end else if (wr_en) begin
      dir_r[idx_r] <= wr_dir;
      dt_r[idx_r]  <= wr_dt;
      ph_r[idx_r]  <= wr_ph;
    end
  end

  // Result selection for the single-answer and timeout-report states.
  always_comb begin
    res = '0;
    if (state_r == ST_EMIT) begin
      res.kind         = KIND_TIMEOUT;
      res.report_block = 8'(idx_r >> 1) + 8'd1;
      res.actuator_sel = idx_r[0];
      res.last         = ((to_mask_r & ~(NUM_ACT'(1) << idx_r)) == '0);
    end else begin
      res.last = 1'b1;
      priority if (func_r == FUNC_PING) begin
        res.kind = KIND_PONG;
      end else if (func_r == FUNC_BLOCK && id_unknown) begin
        res.kind         = KIND_UNKNOWN;
        res.report_block = id_r;
      end else if (func_r == FUNC_BLOCK) begin
        res.kind         = KIND_BLK_ACK;
        res.report_block = id_r;
        res.action_echo  = action_r;
      end else if (action_r == ACT_STOP) begin
        res.kind        = KIND_ALL_STOP;
        res.action_echo = ACT_STOP;
      end else begin
        res.kind        = KIND_ALL_ACK;
        res.action_echo = action_r;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    func_nxt    = func_r;
    id_nxt      = id_r;
    action_nxt  = action_r;
    to_mask_nxt = to_mask_r;
    load        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt   = in_tuser;
          id_nxt     = in_tdata[7:0];
          action_nxt = in_tdata[9:8];
          idx_nxt    = '0;
          to_mask_nxt = '0;
          if (in_tuser == FUNC_PING ||
              (in_tuser == FUNC_BLOCK &&
               (in_tdata[7:0] == 8'd0 || in_tdata[7:0] > 8'(BLOCK_COUNT)))) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (wr_to) begin
          to_mask_nxt[idx_r] = 1'b1;
        end
        if (idx_r == IDX_LAST) begin
          idx_nxt   = '0;
          state_nxt = (func_r == FUNC_TICK) ? ST_EMIT : ST_RESP;
        end else begin
          idx_nxt = idx_r + ACT_W'(1);
        end
      end
      ST_EMIT: begin
        if (to_mask_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (to_mask_r[idx_r]) begin
          if (slot_free) begin
            load                 = 1'b1;
            to_mask_nxt[idx_r]   = 1'b0;
            idx_nxt              = idx_r + ACT_W'(1);
          end
        end else begin
          idx_nxt = idx_r + ACT_W'(1);
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid_nxt = load | (out_tvalid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      to_mask_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      to_mask_r    <= to_mask_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    id_r     <= id_nxt;
    action_r <= action_nxt;
    if (load) begin
      out_tuser_r <= res.kind;
      out_tdata_r <= {5'd0, relay_lv, res.action_echo, res.actuator_sel,
                      res.report_block};
      out_tlast_r <= res.last;
    end
  end

`ifndef SYNTHESIS
  logic [NUM_ACT-1:0] dir_on;
  logic [NUM_ACT-1:0] dir_bad;

  always_comb begin
    for (int a = 0; a < NUM_ACT; a++) begin
      dir_on[a]  = (dir_r[a] != DIR_OFF);
      dir_bad[a] = (dir_r[a] == 2'd3);
    end
  end

  a_mask_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (to_mask_r == '0))
    else $error("timeout mask not empty while idle");

  a_deadtime_needs_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (dt_r & ~dir_on) == '0)
    else $error("actuator waits in deadtime without a direction");

  a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
    dir_bad == '0)
    else $error("illegal direction code stored");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second transaction taken while the first is in work");
`endif

endmodule

`default_nettype wire
